@@ src/ddmc_pkg.sv @@
// Shared types, decision tables and lookup functions of the door drive mode controller.
package ddmc_pkg;

    // Drive bit positions inside a table entry.
    localparam int unsigned DRV_OPEN  = 0;
    localparam int unsigned DRV_CLOSE = 1;
    localparam int unsigned DRV_LAMP  = 2;

    localparam logic [2:0] DRV_NONE = 3'b000;
    localparam logic [2:0] DRV_OP   = 3'b001;
    localparam logic [2:0] DRV_CL   = 3'b110;
    localparam logic [2:0] DRV_WARN = 3'b100;

    localparam int unsigned HOLD_W    = 16;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;
    localparam logic [HOLD_W-1:0] CLOSE_DELAY_RST = 16'd50;

    // Register index, taken from the word address bit.
    localparam logic REG_CLOSE_DELAY = 1'b0;

    typedef enum logic [2:0] {
        RUN_NONE   = 3'b001,
        RUN_MANUAL = 3'b010,
        RUN_AUTO   = 3'b100
    } t_mode;

    typedef enum logic [2:0] {
        M_REST    = 3'b001,
        M_CLOSING = 3'b010,
        M_OPENING = 3'b100
    } t_man_phase;

    typedef enum logic [3:0] {
        A_MOVING  = 4'b0001,
        A_BARRIER = 4'b0010,
        A_REST    = 4'b0100,
        A_INITIAL = 4'b1000
    } t_auto_phase;

    typedef struct packed {
        t_man_phase phase;
        logic [2:0] drv;
    } t_man_ent;

    typedef struct packed {
        t_auto_phase phase;
        logic [2:0]  drv;
    } t_auto_ent;

    function automatic t_man_ent me(t_man_phase ph, logic [2:0] drv);
        t_man_ent ent;
        ent.phase = ph;
        ent.drv   = drv;
        return ent;
    endfunction

    function automatic t_auto_ent ae(t_auto_phase ph, logic [2:0] drv);
        t_auto_ent ent;
        ent.phase = ph;
        ent.drv   = drv;
        return ent;
    endfunction

    // Manual tables, index {open_limit, open_button, closed_limit, close_button}.
    localparam t_man_ent MAN_TAB_REST [16] = '{
        me(M_REST, DRV_NONE), me(M_REST, DRV_NONE), me(M_REST, DRV_NONE),
        me(M_REST, DRV_NONE),
        me(M_REST, DRV_NONE), me(M_REST, DRV_NONE), me(M_OPENING, DRV_OP),
        me(M_OPENING, DRV_OP),
        me(M_REST, DRV_NONE), me(M_CLOSING, DRV_CL), me(M_REST, DRV_NONE),
        me(M_REST, DRV_NONE),
        me(M_REST, DRV_NONE), me(M_REST, DRV_NONE), me(M_REST, DRV_NONE),
        me(M_REST, DRV_NONE)
    };

    localparam t_man_ent MAN_TAB_CLOSING [16] = '{
        me(M_CLOSING, DRV_CL), me(M_CLOSING, DRV_CL), me(M_REST, DRV_NONE),
        me(M_REST, DRV_NONE),
        me(M_OPENING, DRV_OP), me(M_OPENING, DRV_OP), me(M_OPENING, DRV_OP),
        me(M_OPENING, DRV_OP),
        me(M_CLOSING, DRV_CL), me(M_CLOSING, DRV_CL),
        me(M_CLOSING, DRV_NONE), me(M_CLOSING, DRV_NONE),
        me(M_REST, DRV_NONE), me(M_REST, DRV_NONE),
        me(M_CLOSING, DRV_NONE), me(M_CLOSING, DRV_NONE)
    };

    localparam t_man_ent MAN_TAB_OPENING [16] = '{
        me(M_OPENING, DRV_OP), me(M_OPENING, DRV_NONE),
        me(M_OPENING, DRV_OP), me(M_OPENING, DRV_OP),
        me(M_OPENING, DRV_OP), me(M_OPENING, DRV_OP), me(M_OPENING, DRV_OP),
        me(M_OPENING, DRV_OP),
        me(M_REST, DRV_NONE), me(M_OPENING, DRV_NONE),
        me(M_OPENING, DRV_NONE), me(M_OPENING, DRV_NONE),
        me(M_REST, DRV_NONE), me(M_REST, DRV_NONE),
        me(M_OPENING, DRV_NONE), me(M_OPENING, DRV_NONE)
    };

    // Automatic tables, index {open_limit, closed_limit, any_barrier}.
    localparam t_auto_ent AUTO_TAB_MOVING [8] = '{
        ae(A_MOVING, DRV_CL), ae(A_MOVING, DRV_OP), ae(A_REST, DRV_NONE), ae(A_MOVING, DRV_NONE),
        ae(A_REST, DRV_NONE), ae(A_BARRIER, DRV_NONE), ae(A_MOVING, DRV_NONE),
        ae(A_MOVING, DRV_NONE)
    };

    localparam t_auto_ent AUTO_TAB_BARRIER [8] = '{
        ae(A_MOVING, DRV_OP), ae(A_BARRIER, DRV_OP), ae(A_BARRIER, DRV_OP),
        ae(A_BARRIER, DRV_NONE),
        ae(A_REST, DRV_NONE), ae(A_BARRIER, DRV_NONE), ae(A_BARRIER, DRV_NONE),
        ae(A_BARRIER, DRV_NONE)
    };

    localparam t_auto_ent AUTO_TAB_REST [8] = '{
        ae(A_REST, DRV_NONE), ae(A_REST, DRV_NONE), ae(A_REST, DRV_NONE), ae(A_BARRIER, DRV_OP),
        ae(A_MOVING, DRV_CL), ae(A_BARRIER, DRV_NONE), ae(A_REST, DRV_NONE), ae(A_REST, DRV_NONE)
    };

    localparam t_auto_ent AUTO_TAB_INITIAL [8] = '{
        ae(A_MOVING, DRV_OP), ae(A_BARRIER, DRV_OP), ae(A_REST, DRV_OP), ae(A_BARRIER, DRV_OP),
        ae(A_REST, DRV_OP), ae(A_BARRIER, DRV_OP), ae(A_INITIAL, DRV_NONE),
        ae(A_INITIAL, DRV_NONE)
    };

    function automatic t_man_ent man_lookup(t_man_phase ph, logic [3:0] idx);
        t_man_ent ent;
        case (ph)
            M_CLOSING: ent = MAN_TAB_CLOSING[idx];
            M_OPENING: ent = MAN_TAB_OPENING[idx];
            default:   ent = MAN_TAB_REST[idx];
        endcase
        return ent;
    endfunction

    function automatic t_auto_ent auto_lookup(t_auto_phase ph, logic [2:0] idx);
        t_auto_ent ent;
        case (ph)
            A_MOVING:  ent = AUTO_TAB_MOVING[idx];
            A_BARRIER: ent = AUTO_TAB_BARRIER[idx];
            A_REST:    ent = AUTO_TAB_REST[idx];
            default:   ent = AUTO_TAB_INITIAL[idx];
        endcase
        return ent;
    endfunction

endpackage

@@ src/ddmc_if.sv @@
// Valid/ready channel interfaces for sensor samples and drive results.
interface ddmc_req_if;
    logic valid;
    logic ready;
    logic auto_select;
    logic at_open_limit;
    logic at_closed_limit;
    logic open_button;
    logic close_button;
    logic approach_barrier;
    logic collision_barrier;

    modport source (
        output valid, auto_select, at_open_limit, at_closed_limit, open_button,
               close_button, approach_barrier, collision_barrier,
        input  ready
    );
    modport sink (
        input  valid, auto_select, at_open_limit, at_closed_limit, open_button,
               close_button, approach_barrier, collision_barrier,
        output ready
    );
endinterface

interface ddmc_rsp_if;
    logic       valid;
    logic       ready;
    logic       drive_open;
    logic       drive_close;
    logic       warn_light;
    logic [1:0] fault_bits;

    modport source (
        output valid, drive_open, drive_close, warn_light, fault_bits,
        input  ready
    );
    modport sink (
        input  valid, drive_open, drive_close, warn_light, fault_bits,
        output ready
    );
endinterface

@@ src/door_drive_mode_controller.sv @@
// Door drive mode controller: manual and automatic door state machines with fault checks.
// A request accepted into the input register passes on into the result register, where its
// result waits until it is taken.
// Throughput: one request per cycle; the input register and the result register each
// advance whenever the result register is empty or its result is being taken.
// Reset (synchronous, active low) empties both registers and restores all state defaults.
module door_drive_mode_controller
    import ddmc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    ddmc_req_if.sink           i_req,
    ddmc_rsp_if.source         o_rsp,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output logic [PDATA_W-1:0] o_prdata,
    output logic               o_pready
);

    // ------------------------------------------------------------------
    // Configuration register. Only the close delay exists; it sits at the
    // word with address bit 2 clear. The other word reads as zero and
    // ignores writes. The close delay comes out of reset at 50 ticks.
    // ------------------------------------------------------------------
    logic [HOLD_W-1:0] r_close_delay;
    logic              cfg_wr;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel & i_penable & i_pwrite & o_pready
                      & (i_paddr[2] == REG_CLOSE_DELAY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_close_delay <= CLOSE_DELAY_RST;
        end else if (cfg_wr) begin
            r_close_delay <= i_pwdata[HOLD_W-1:0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (i_paddr[2] == REG_CLOSE_DELAY) begin
            o_prdata = {{(PDATA_W-HOLD_W){1'b0}}, r_close_delay};
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. The input register refills in the same cycle as it
    // drains, so a new request can enter every cycle while the downstream
    // side keeps taking results.
    // ------------------------------------------------------------------
    logic r_in_vld;
    logic r_out_vld;
    logic advance;
    logic take_in;

    assign advance     = !r_out_vld || o_rsp.ready;
    assign i_req.ready = !r_in_vld || advance;
    assign take_in     = i_req.valid && i_req.ready;

    // Captured sensor sample.
    logic r_as;
    logic r_ol;
    logic r_cl;
    logic r_ob;
    logic r_cb;
    logic r_lb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (take_in) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    // The two light barriers only ever matter together, so they are merged here.
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_as <= i_req.auto_select;
            r_ol <= i_req.at_open_limit;
            r_cl <= i_req.at_closed_limit;
            r_ob <= i_req.open_button;
            r_cb <= i_req.close_button;
            r_lb <= i_req.approach_barrier | i_req.collision_barrier;
        end
    end

    // ------------------------------------------------------------------
    // Controller state. After reset no mode is active, the manual machine
    // is at rest, the automatic machine is initial and the hold counter is
    // zero.
    // ------------------------------------------------------------------
    t_mode             r_mode;
    t_man_phase        r_man_phase;
    t_auto_phase       r_auto_phase;
    logic [HOLD_W-1:0] r_hold;

    t_mode             n_mode;
    t_man_phase        n_man_phase;
    t_auto_phase       n_auto_phase;
    logic [HOLD_W-1:0] n_hold;

    t_man_phase        man_ph;
    t_auto_phase       auto_ph;
    logic [HOLD_W-1:0] hold_cur;
    t_man_ent          man_ent;
    t_auto_ent         auto_ent;
    logic [2:0]        drv;
    logic [1:0]        fault;

    logic              n_drive_open;
    logic              n_drive_close;
    logic              n_warn_light;
    logic [1:0]        n_fault_bits;

    always_comb begin
        // A machine that was not the one running on the previous tick starts
        // from its reset phase; the automatic one also restarts its hold counter.
        man_ph   = (r_mode == RUN_MANUAL) ? r_man_phase : M_REST;
        auto_ph  = (r_mode == RUN_AUTO) ? r_auto_phase : A_INITIAL;
        hold_cur = (r_mode == RUN_AUTO) ? r_hold : '0;

        man_ent  = man_lookup(man_ph, {r_ol, r_ob, r_cl, r_cb});
        auto_ent = auto_lookup(auto_ph, {r_ol, r_cl, r_lb});

        n_man_phase  = r_man_phase;
        n_auto_phase = r_auto_phase;
        n_hold       = r_hold;

        if (r_as) begin
            drv          = auto_ent.drv;
            n_auto_phase = auto_ent.phase;
            // Closing is held back while the counter runs down. Any tick that
            // does not ask for the close motor rearms the counter.
            if (drv[DRV_CLOSE]) begin
                n_hold = hold_cur;
                if (hold_cur != '0) begin
                    n_hold         = hold_cur - 1'b1;
                    drv[DRV_CLOSE] = 1'b0;
                    drv[DRV_LAMP]  = 1'b0;
                end
            end else begin
                n_hold = r_close_delay;
            end
            n_mode = RUN_AUTO;
        end else begin
            drv         = man_ent.drv;
            n_man_phase = man_ent.phase;
            n_mode      = RUN_MANUAL;
        end

        // Both end switches at once, or a motor driven while either end switch is
        // active, is a fault: motors off, lamp on, and the next request re-initializes.
        fault[0] = r_ol & r_cl;
        fault[1] = (r_ol | r_cl) & (drv[DRV_OPEN] | drv[DRV_CLOSE]);
        if (fault != 2'b00) begin
            drv    = DRV_WARN;
            n_mode = RUN_NONE;
        end

        n_drive_open  = drv[DRV_OPEN];
        n_drive_close = drv[DRV_CLOSE];
        n_warn_light  = drv[DRV_LAMP];
        n_fault_bits  = fault;
    end

    // State moves only when a request actually passes into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= RUN_NONE;
            r_man_phase  <= M_REST;
            r_auto_phase <= A_INITIAL;
            r_hold       <= '0;
        end else if (r_in_vld && advance) begin
            r_mode       <= n_mode;
            r_man_phase  <= n_man_phase;
            r_auto_phase <= n_auto_phase;
            r_hold       <= n_hold;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld && advance) begin
            o_rsp.drive_open  <= n_drive_open;
            o_rsp.drive_close <= n_drive_close;
            o_rsp.warn_light  <= n_warn_light;
            o_rsp.fault_bits  <= n_fault_bits;
        end
    end

    assign o_rsp.valid = r_out_vld;

endmodule
